// ----- rtl/wsdw_pkg.sv -----
// ----------------------------------------------------------------------------
// wsdw_pkg
// shared codes, widths and command/result records for the task deque
// ----------------------------------------------------------------------------
package wsdw_pkg;

  // fixed field widths
  localparam int ACT_W   = 2;
  localparam int LIMIT_W = 6;
  localparam int MARK_W  = 9;
  localparam int REG_W   = 2;

  // record widths, sized for the largest legal configuration
  localparam int ADDR_W  = 16;
  localparam int OCC_W   = 17;
  localparam int BATCH_W = 7;
  localparam int TASK_W  = 64;

  // action codes
  localparam logic [ACT_W-1:0] ACT_PUSH  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_STEAL = 2'd2;

  // register indexes
  localparam logic [REG_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [REG_W-1:0] REG_HIGH   = 2'd1;
  localparam logic [REG_W-1:0] REG_LOW    = 2'd2;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_REFUSE,
    CMD_EMPTY,
    CMD_BATCH
  } cmd_kind_t;

  // classified item, front to back
  typedef struct packed {
    cmd_kind_t            kind;
    logic                 from_back;
    logic [BATCH_W-1:0]   count;
    logic [ADDR_W-1:0]    addr;
    logic [OCC_W-1:0]     occ;
    logic                 flag;
    logic [TASK_W-1:0]    word;
  } cmd_t;

  // result status, travels beside the store read data
  typedef struct packed {
    logic                 task_valid;
    logic                 last;
    logic                 refused;
    logic [OCC_W-1:0]     occ;
    logic                 flag;
  } res_t;

endpackage

// ----- rtl/wsdw_ram.sv -----
// ----------------------------------------------------------------------------
// wsdw_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module wsdw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/wsdw_fifo.sv -----
// ----------------------------------------------------------------------------
// wsdw_fifo
// two-entry command queue between classifier and executor
// ----------------------------------------------------------------------------
module wsdw_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wsdw_pkg::cmd_t cmd_in,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output wsdw_pkg::cmd_t head
);

  wsdw_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- rtl/wsdw_front.sv -----
// ----------------------------------------------------------------------------
// wsdw_front
// accepts items and config writes, owns occupancy, indexes and flag
// ----------------------------------------------------------------------------
module wsdw_front #(
  parameter int QUEUE_DEPTH = 256,
  parameter int MAX_BATCH   = 32,
  parameter int TASK_BITS   = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [wsdw_pkg::ACT_W-1:0]     action,
  input  logic [TASK_BITS-1:0]           task_word,
  input  logic [wsdw_pkg::LIMIT_W-1:0]   batch_limit,
  input  logic                           cfg_write,
  input  logic [wsdw_pkg::REG_W-1:0]     cfg_index,
  input  logic [wsdw_pkg::MARK_W-1:0]    cfg_data,
  input  logic                           q_full,
  output logic                           busy,
  output logic                           q_push,
  output wsdw_pkg::cmd_t                 cmd
);

  localparam int AW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int CMPW = (CW > wsdw_pkg::MARK_W) ? CW : wsdw_pkg::MARK_W;
  localparam int SW   = CMPW + 1;

  logic [AW-1:0]               front_index;
  logic [CW-1:0]               held;
  logic                        flag;
  logic                        pub_en;
  logic [wsdw_pkg::MARK_W-1:0] high_mark;
  logic [wsdw_pkg::MARK_W-1:0] low_mark;

  logic                        accept;
  logic [SW-1:0]               held_w;
  logic [SW-1:0]               front_w;
  logic [SW-1:0]               lim_w;
  logic [SW-1:0]               take_w;
  logic [SW-1:0]               tail_w;
  logic [SW-1:0]               newest_w;
  logic [SW-1:0]               step_w;
  logic [AW-1:0]               front_next;
  logic [CW-1:0]               held_next;
  logic                        changed;
  logic                        active;
  logic                        flag_next;

  logic                        cfg_hit;
  logic                        en_c;
  logic [wsdw_pkg::MARK_W-1:0] hi_c;
  logic [wsdw_pkg::MARK_W-1:0] lo_c;
  logic                        active_c;

  assign accept = start & ~q_full;
  assign busy   = q_full;
  assign q_push = accept;

  always_comb begin
    held_w  = SW'(held);
    front_w = SW'(front_index);
    lim_w   = (SW'(batch_limit) > SW'(MAX_BATCH)) ? SW'(MAX_BATCH) : SW'(batch_limit);
    take_w  = (lim_w < held_w) ? lim_w : held_w;

    // slot after the newest task
    tail_w = front_w + held_w;
    if (tail_w >= SW'(QUEUE_DEPTH)) begin
      tail_w = tail_w - SW'(QUEUE_DEPTH);
    end
    // newest task, only used when the store is not empty
    newest_w = front_w + held_w - SW'(1);
    if (newest_w >= SW'(QUEUE_DEPTH)) begin
      newest_w = newest_w - SW'(QUEUE_DEPTH);
    end
    // front after a steal
    step_w = front_w + take_w;
    if (step_w >= SW'(QUEUE_DEPTH)) begin
      step_w = step_w - SW'(QUEUE_DEPTH);
    end

    front_next    = front_index;
    held_next     = held;
    changed       = 1'b0;
    cmd           = '0;
    cmd.kind      = wsdw_pkg::CMD_EMPTY;
    cmd.word[TASK_BITS-1:0] = task_word;

    unique case (action)
      wsdw_pkg::ACT_PUSH: begin
        if (held_w == SW'(QUEUE_DEPTH)) begin
          cmd.kind = wsdw_pkg::CMD_REFUSE;
        end else begin
          cmd.kind  = wsdw_pkg::CMD_PUSH;
          cmd.addr  = wsdw_pkg::ADDR_W'(tail_w[AW-1:0]);
          held_next = held + CW'(1);
          changed   = 1'b1;
        end
      end
      wsdw_pkg::ACT_POP: begin
        if (take_w != '0) begin
          cmd.kind      = wsdw_pkg::CMD_BATCH;
          cmd.from_back = 1'b1;
          cmd.count     = wsdw_pkg::BATCH_W'(take_w);
          cmd.addr      = wsdw_pkg::ADDR_W'(newest_w[AW-1:0]);
          held_next     = held - CW'(take_w);
          changed       = 1'b1;
        end
      end
      wsdw_pkg::ACT_STEAL: begin
        if (take_w != '0) begin
          cmd.kind      = wsdw_pkg::CMD_BATCH;
          cmd.from_back = 1'b0;
          cmd.count     = wsdw_pkg::BATCH_W'(take_w);
          cmd.addr      = wsdw_pkg::ADDR_W'(front_index);
          held_next     = held - CW'(take_w);
          front_next    = step_w[AW-1:0];
          changed       = 1'b1;
        end
      end
      default: begin
        cmd.kind = wsdw_pkg::CMD_EMPTY;
      end
    endcase

    // hysteresis on the final occupancy
    active = pub_en && (high_mark != '0) && (low_mark != '0) && (low_mark < high_mark);
    flag_next = flag;
    if (active && changed) begin
      if (!flag && (SW'(held_next) > SW'(high_mark))) begin
        flag_next = 1'b1;
      end else if (flag && (SW'(held_next) < SW'(low_mark))) begin
        flag_next = 1'b0;
      end
    end
    cmd.occ  = wsdw_pkg::OCC_W'(held_next);
    cmd.flag = flag_next;
  end

  // register file after the write, used for re-evaluation
  always_comb begin
    en_c    = pub_en;
    hi_c    = high_mark;
    lo_c    = low_mark;
    cfg_hit = 1'b0;
    if (cfg_write) begin
      unique case (cfg_index)
        wsdw_pkg::REG_ENABLE: begin
          en_c    = cfg_data[0];
          cfg_hit = 1'b1;
        end
        wsdw_pkg::REG_HIGH: begin
          hi_c    = cfg_data;
          cfg_hit = 1'b1;
        end
        wsdw_pkg::REG_LOW: begin
          lo_c    = cfg_data;
          cfg_hit = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
    active_c = en_c && (hi_c != '0) && (lo_c != '0) && (lo_c < hi_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      held        <= '0;
      flag        <= 1'b0;
      pub_en      <= 1'b0;
      high_mark   <= '0;
      low_mark    <= '0;
    end else begin
      pub_en    <= en_c;
      high_mark <= hi_c;
      low_mark  <= lo_c;
      if (accept) begin
        front_index <= front_next;
        held        <= held_next;
      end
      if (cfg_hit && active_c) begin
        flag <= (held_w > SW'(hi_c));
      end else if (accept) begin
        flag <= flag_next;
      end
    end
  end

endmodule

// ----- rtl/wsdw_back.sv -----
// ----------------------------------------------------------------------------
// wsdw_back
// executes queued commands against the store, one result per cycle while a command is queued
// ----------------------------------------------------------------------------
module wsdw_back #(
  parameter int QUEUE_DEPTH = 256,
  parameter int TASK_BITS   = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  wsdw_pkg::cmd_t                 head,
  output logic                           q_pop,
  output logic                           ram_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0] ram_waddr,
  output logic [TASK_BITS-1:0]           ram_wdata,
  output logic [$clog2(QUEUE_DEPTH)-1:0] ram_raddr,
  input  logic [TASK_BITS-1:0]           ram_rdata,
  output logic                           result_valid,
  output logic [TASK_BITS-1:0]           out_task,
  output logic                           task_valid,
  output logic                           last_of_batch,
  output logic                           push_refused,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] occupancy,
  output logic                           stealable
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic                         running;
  logic [wsdw_pkg::BATCH_W-1:0] left;
  logic [AW-1:0]                addr_run;
  wsdw_pkg::res_t               res;

  logic [wsdw_pkg::BATCH_W-1:0] cur_left;
  logic [AW-1:0]                cur_addr;
  logic [AW-1:0]                addr_step;
  logic                         is_last;
  wsdw_pkg::res_t               res_next;

  always_comb begin
    cur_left = running ? left : head.count;
    cur_addr = running ? addr_run : head.addr[AW-1:0];
    is_last  = (cur_left == wsdw_pkg::BATCH_W'(1));

    if (head.from_back) begin
      addr_step = (cur_addr == '0) ? AW'(QUEUE_DEPTH - 1) : cur_addr - AW'(1);
    end else begin
      addr_step = (cur_addr == AW'(QUEUE_DEPTH - 1)) ? '0 : cur_addr + AW'(1);
    end

    ram_we    = 1'b0;
    ram_waddr = head.addr[AW-1:0];
    ram_wdata = head.word[TASK_BITS-1:0];
    ram_raddr = cur_addr;
    q_pop     = 1'b0;

    res_next            = '0;
    res_next.last       = 1'b1;
    res_next.occ        = head.occ;
    res_next.flag       = head.flag;

    if (!q_empty) begin
      unique case (head.kind)
        wsdw_pkg::CMD_PUSH: begin
          ram_we = 1'b1;
          q_pop  = 1'b1;
        end
        wsdw_pkg::CMD_REFUSE: begin
          res_next.refused = 1'b1;
          q_pop            = 1'b1;
        end
        wsdw_pkg::CMD_EMPTY: begin
          q_pop = 1'b1;
        end
        wsdw_pkg::CMD_BATCH: begin
          res_next.task_valid = 1'b1;
          res_next.last       = is_last;
          q_pop               = is_last;
        end
        default: begin
          q_pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (!q_empty && head.kind == wsdw_pkg::CMD_BATCH) begin
      left     <= cur_left - wsdw_pkg::BATCH_W'(1);
      addr_run <= addr_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= !q_empty;
      if (!q_empty && head.kind == wsdw_pkg::CMD_BATCH) begin
        running <= !is_last;
      end
    end
  end

  // store read data lines up with the registered status
  assign out_task      = res.task_valid ? ram_rdata : '0;
  assign task_valid    = res.task_valid;
  assign last_of_batch = res.last;
  assign push_refused  = res.refused;
  assign occupancy     = res.occ[CW-1:0];
  assign stealable     = res.flag;

endmodule

// ----- rtl/work_stealing_deque_watermark_unit.sv -----
// ----------------------------------------------------------------------------
// work_stealing_deque_watermark_unit
// bounded task deque with batch pop/steal and a hysteresis stealable flag
// ----------------------------------------------------------------------------
//
// channel   | ports                                          | handshake
// ----------+------------------------------------------------+---------------------------
// item in   | action, task_word, batch_limit                 | start high, busy low
// result    | out_task, task_valid, last_of_batch,           | result_valid, one cycle,
//           | push_refused, occupancy, stealable             | no back-pressure
// config    | cfg_index, cfg_data                            | cfg_write, taken at once
//
// a push, refused push, empty batch or unused action gives its result once the item
// has passed the command queue and the result register; a batch of n tasks streams
// n results one per cycle, paced by the single read port of the task store
// the front classifies an item in its accept cycle; a two-entry queue lets it take
// more items while the back works, and busy rises only when that queue is full
// reset clears indexes, occupancy, flag and registers; the store is not cleared and
// needs no clearing pass since only pushed entries are ever read
// results cannot be stalled, so the back never waits on the receiver
//
module work_stealing_deque_watermark_unit #(
  parameter int QUEUE_DEPTH = 256,
  parameter int MAX_BATCH   = 32,
  parameter int TASK_BITS   = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  // item in
  input  logic                             start,
  output logic                             busy,
  input  logic [wsdw_pkg::ACT_W-1:0]       action,
  input  logic [TASK_BITS-1:0]             task_word,
  input  logic [wsdw_pkg::LIMIT_W-1:0]     batch_limit,
  // configuration
  input  logic                             cfg_write,
  input  logic [wsdw_pkg::REG_W-1:0]       cfg_index,
  input  logic [wsdw_pkg::MARK_W-1:0]      cfg_data,
  // results
  output logic                             result_valid,
  output logic [TASK_BITS-1:0]             out_task,
  output logic                             task_valid,
  output logic                             last_of_batch,
  output logic                             push_refused,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] occupancy,
  output logic                             stealable
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  // front to queue
  logic           q_push;
  wsdw_pkg::cmd_t cmd_in;
  logic           q_full;

  // queue to back
  logic           q_pop;
  logic           q_empty;
  wsdw_pkg::cmd_t head;

  // task store
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [TASK_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [TASK_BITS-1:0] ram_rdata;

  // classifier: takes items and config, keeps occupancy and the published flag
  wsdw_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_BATCH   (MAX_BATCH),
    .TASK_BITS   (TASK_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .action      (action),
    .task_word   (task_word),
    .batch_limit (batch_limit),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .busy        (busy),
    .q_push      (q_push),
    .cmd         (cmd_in)
  );

  // decoupling queue, keeps store writes and reads in item order
  wsdw_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .cmd_in (cmd_in),
    .pop    (q_pop),
    .full   (q_full),
    .empty  (q_empty),
    .head   (head)
  );

  // executor: writes pushed tasks, walks batches through the store
  wsdw_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TASK_BITS   (TASK_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .head          (head),
    .q_pop         (q_pop),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .result_valid  (result_valid),
    .out_task      (out_task),
    .task_valid    (task_valid),
    .last_of_batch (last_of_batch),
    .push_refused  (push_refused),
    .occupancy     (occupancy),
    .stealable     (stealable)
  );

  // task store, circular buffer indexed by the front
  wsdw_ram #(
    .WIDTH (TASK_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
